/* rtl/gpc_pkg.sv */
// Shared types and constants for the GPIO port controller.
// Holds op and register codes and the transaction structs; no dependencies.
package gpc_pkg;

  typedef logic [1:0] gpc_op_t;
  typedef logic [3:0] gpc_reg_t;

  localparam gpc_op_t OpRead   = 2'd0;
  localparam gpc_op_t OpWrite  = 2'd1;
  localparam gpc_op_t OpSample = 2'd2;

  // Register codes, address bits 7:4
  localparam gpc_reg_t RegMode    = 4'h0;
  localparam gpc_reg_t RegOutEn   = 4'h1;
  localparam gpc_reg_t RegOut     = 4'h2;
  localparam gpc_reg_t RegIn      = 4'h3;
  localparam gpc_reg_t RegStatus  = 4'h4;
  localparam gpc_reg_t RegEnable  = 4'h5;
  localparam gpc_reg_t RegLevel   = 4'h6;
  localparam gpc_reg_t RegClear   = 4'h7;
  localparam gpc_reg_t RegDbCtrl  = 4'hB;
  localparam gpc_reg_t RegDbCount = 4'hF;

  typedef struct packed {
    gpc_op_t     op;
    logic [10:0] address;
    logic [23:0] write_data;
    logic [4:0]  sample_port;
    logic [7:0]  pin_levels;
  } gpc_item_t;

  typedef struct packed {
    logic [23:0] read_data;
    logic [4:0]  drive_port;
    logic [7:0]  drive_levels;
    logic [7:0]  drive_enables;
    logic [7:0]  bank_irq;
  } gpc_result_t;

endpackage

/* rtl/gpc_in_reg.sv */
// Input register of the GPIO port controller: holds one accepted transaction.
// Depends on gpc_pkg for the transaction struct.
module gpc_in_reg import gpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gpc_item_t item_i,
  input  logic      take_i,
  output logic      valid_o,
  output gpc_item_t item_o
);

  logic      vld_q, vld_d;
  gpc_item_t item_q;
  logic      advance;

  // Register may load when empty or when its content leaves this cycle
  assign advance    = !vld_q || take_i;
  assign in_stall_o = !advance;
  assign vld_d      = advance ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

/* rtl/gpc_port_file.sv */
// Per-port register file and single-pass update logic of the GPIO port controller.
// Depends on gpc_pkg for codes and the transaction structs.
module gpc_port_file import gpc_pkg::*; #(
  parameter int NUM_BANKS      = 8,
  parameter int PORTS_PER_BANK = 4,
  parameter int PINS_PER_PORT  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  gpc_item_t   item_i,
  output gpc_result_t res_o
);

  localparam int NumPorts = NUM_BANKS * PORTS_PER_BANK;
  localparam int IdxW     = (NumPorts > 1) ? $clog2(NumPorts) : 1;
  localparam int P        = PINS_PER_PORT;

  logic [P-1:0]   mode_q     [NumPorts];
  logic [P-1:0]   oe_q       [NumPorts];
  logic [P-1:0]   out_q      [NumPorts];
  logic [P-1:0]   in_q       [NumPorts];
  logic [P-1:0]   status_q   [NumPorts];
  logic [P-1:0]   enable_q   [NumPorts];
  logic [3*P-1:0] level_q    [NumPorts];
  logic [2*P-1:0] db_ctrl_q  [NumPorts];
  logic [7:0]     db_count_q [NumPorts];
  logic [NumPorts-1:0] pend_q;

  logic [P-1:0]   mode_d, oe_d, out_d, in_d, status_d, enable_d;
  logic [3*P-1:0] level_d;
  logic [2*P-1:0] db_ctrl_d;
  logic [7:0]     db_count_d;
  logic           pend_d;

  logic [2:0]     sel_bank;
  logic [1:0]     sel_port;
  logic           is_sample;
  logic           port_ok;
  logic [5:0]     idx_full;
  logic [IdxW-1:0] idx;
  gpc_reg_t       reg_code;
  logic [P-1:0]   wd_pins;
  logic [23:0]    rdata;

  logic [P-1:0]   now, old, high, edg, delta;
  logic [P-1:0]   level_hit, rise, fall, edge_hit, hit;

  logic [NumPorts-1:0] pend_view;
  logic [7:0]          irq;

  assign is_sample = (item_i.op == OpSample);
  assign sel_bank  = is_sample ? item_i.sample_port[4:2] : item_i.address[10:8];
  assign sel_port  = is_sample ? item_i.sample_port[1:0] : item_i.address[3:2];
  assign port_ok   = ({1'b0, sel_bank} < 4'(NUM_BANKS)) &&
                     ({1'b0, sel_port} < 3'(PORTS_PER_BANK));
  assign idx_full  = 6'(sel_bank) * 6'(PORTS_PER_BANK) + 6'(sel_port);
  assign idx       = idx_full[IdxW-1:0];
  assign reg_code  = item_i.address[7:4];
  assign wd_pins   = item_i.write_data[P-1:0];

  // Interrupt condition per pin on a sample
  assign now       = item_i.pin_levels[P-1:0];
  assign old       = in_q[idx];
  assign high      = level_q[idx][P-1:0];
  assign edg       = level_q[idx][P +: P];
  assign delta     = level_q[idx][2*P +: P];
  assign level_hit = ~(now ^ high);
  assign rise      = now & ~old;
  assign fall      = old & ~now;
  assign edge_hit  = (delta & (now ^ old)) | (~delta & ((high & rise) | (~high & fall)));
  assign hit       = (~edg & level_hit) | (edg & edge_hit);

  always_comb begin
    mode_d     = mode_q[idx];
    oe_d       = oe_q[idx];
    out_d      = out_q[idx];
    in_d       = in_q[idx];
    status_d   = status_q[idx];
    enable_d   = enable_q[idx];
    level_d    = level_q[idx];
    db_ctrl_d  = db_ctrl_q[idx];
    db_count_d = db_count_q[idx];
    rdata      = '0;
    if (port_ok) begin
      case (item_i.op)
        OpRead: begin
          case (reg_code)
            RegMode:    rdata = 24'(mode_q[idx]);
            RegOutEn:   rdata = 24'(oe_q[idx]);
            RegOut:     rdata = 24'(out_q[idx]);
            RegIn:      rdata = 24'(in_q[idx]);
            RegStatus:  rdata = 24'(status_q[idx]);
            RegEnable:  rdata = 24'(enable_q[idx]);
            RegLevel: begin
              rdata[P-1:0]  = level_q[idx][P-1:0];
              rdata[8 +: P] = level_q[idx][P +: P];
              rdata[16 +: P] = level_q[idx][2*P +: P];
            end
            RegDbCtrl: begin
              rdata[P-1:0]  = db_ctrl_q[idx][P-1:0];
              rdata[8 +: P] = db_ctrl_q[idx][P +: P];
            end
            RegDbCount: rdata = 24'(db_count_q[idx]);
            default:    rdata = '0;
          endcase
        end
        OpWrite: begin
          case (reg_code)
            RegMode:    mode_d   = wd_pins;
            RegOutEn:   oe_d     = wd_pins;
            RegOut:     out_d    = wd_pins;
            RegEnable:  enable_d = wd_pins;
            RegLevel:   level_d  = {item_i.write_data[16 +: P], item_i.write_data[8 +: P],
                                    item_i.write_data[0 +: P]};
            RegClear:   status_d = status_q[idx] & ~wd_pins;
            RegDbCtrl:  db_ctrl_d = {item_i.write_data[8 +: P], item_i.write_data[0 +: P]};
            RegDbCount: db_count_d = item_i.write_data[7:0];
            default:    ;
          endcase
        end
        OpSample: begin
          status_d = status_q[idx] | hit;
          in_d     = now;
        end
        default: ;
      endcase
    end
  end

  assign pend_d = |(status_d & enable_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPorts; i++) begin
        mode_q[i]     <= '0;
        oe_q[i]       <= '0;
        out_q[i]      <= '0;
        in_q[i]       <= '0;
        status_q[i]   <= '0;
        enable_q[i]   <= '0;
        level_q[i]    <= '0;
        db_ctrl_q[i]  <= '0;
        db_count_q[i] <= '0;
      end
      pend_q <= '0;
    end else if (fire_i && port_ok) begin
      mode_q[idx]     <= mode_d;
      oe_q[idx]       <= oe_d;
      out_q[idx]      <= out_d;
      in_q[idx]       <= in_d;
      status_q[idx]   <= status_d;
      enable_q[idx]   <= enable_d;
      level_q[idx]    <= level_d;
      db_ctrl_q[idx]  <= db_ctrl_d;
      db_count_q[idx] <= db_count_d;
      pend_q[idx]     <= pend_d;
    end
  end

  // Bank lines reflect the state after this transaction
  always_comb begin
    for (int i = 0; i < NumPorts; i++) begin
      pend_view[i] = (port_ok && (idx_full == 6'(i))) ? pend_d : pend_q[i];
    end
    irq = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int p = 0; p < PORTS_PER_BANK; p++) begin
        irq[b] = irq[b] | pend_view[b * PORTS_PER_BANK + p];
      end
    end
  end

  assign res_o.read_data     = rdata;
  assign res_o.drive_port    = {sel_bank, sel_port};
  assign res_o.drive_levels  = port_ok ? 8'(out_d) : 8'h00;
  assign res_o.drive_enables = port_ok ? 8'(oe_d & mode_d) : 8'h00;
  assign res_o.bank_irq      = irq;

endmodule

/* rtl/gpc_out_reg.sv */
// Result register of the GPIO port controller: holds one finished transaction.
// Depends on gpc_pkg for the result struct.
module gpc_out_reg import gpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  gpc_result_t res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output gpc_result_t res_o
);

  logic        vld_q, vld_d;
  gpc_result_t res_q;

  assign free_o = !vld_q || !out_stall_i;
  assign vld_d  = free_o ? load_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

/* rtl/gpio_port_controller.sv */
// GPIO port controller: NUM_BANKS banks of PORTS_PER_BANK ports of PINS_PER_PORT pins, reached
// by register reads and writes and fed pin levels by sample transactions. Each transaction is
// taken into an input register, processed in one pass against the per-port register file
// (flip-flops, cleared at reset) and placed in a result register that presents it on the outputs
// until it is taken; the input register takes the next transaction as the last one moves on, so
// one transaction is taken per cycle whenever the result side does not stall. Every
// transaction returns one result: read data (zero except on reads), the drive levels and
// enables of the addressed or sampled port, and the bank interrupt lines, all as they stand
// after the transaction. Debounce registers are stored and read back only.
// Depends on gpc_pkg, gpc_in_reg, gpc_port_file and gpc_out_reg.
module gpio_port_controller import gpc_pkg::*; #(
  parameter int NUM_BANKS      = 8,
  parameter int PORTS_PER_BANK = 4,
  parameter int PINS_PER_PORT  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [10:0] address_i,
  input  logic [23:0] write_data_i,
  input  logic [4:0]  sample_port_i,
  input  logic [7:0]  pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] read_data_o,
  output logic [4:0]  drive_port_o,
  output logic [7:0]  drive_levels_o,
  output logic [7:0]  drive_enables_o,
  output logic [7:0]  bank_irq_o
);

  gpc_item_t   in_item, cur_item;
  gpc_result_t cur_res, out_res;
  logic        cur_valid, out_free, fire;

  assign in_item.op          = op_i;
  assign in_item.address     = address_i;
  assign in_item.write_data  = write_data_i;
  assign in_item.sample_port = sample_port_i;
  assign in_item.pin_levels  = pin_levels_i;

  // Process the held transaction when the result register can take it
  assign fire = cur_valid && out_free;

  gpc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (fire),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  gpc_port_file #(
    .NUM_BANKS      (NUM_BANKS),
    .PORTS_PER_BANK (PORTS_PER_BANK),
    .PINS_PER_PORT  (PINS_PER_PORT)
  ) u_port_file (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (cur_item),
    .res_o  (cur_res)
  );

  gpc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (cur_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign read_data_o     = out_res.read_data;
  assign drive_port_o    = out_res.drive_port;
  assign drive_levels_o  = out_res.drive_levels;
  assign drive_enables_o = out_res.drive_enables;
  assign bank_irq_o      = out_res.bank_irq;

endmodule

/* tb/tb.sv */
// Self-checking testbench for gpio_port_controller: directed register map and interrupt tests,
// then random port traffic with idling on both channels, checked result by result.
// Depends on gpc_pkg and the gpio_port_controller RTL; reads no files.
module tb;
  import gpc_pkg::*;

  localparam int NumBanks     = 8;
  localparam int PortsPerBank = 4;
  localparam int PinsPerPort  = 8;
  localparam logic [7:0] PinMask = 8'((1 << PinsPerPort) - 1);
  localparam gpc_op_t  OpNone      = 2'd3;
  localparam gpc_reg_t RegReserved = 4'hA;
  localparam int IdleLimit   = 300;
  localparam int SettleCycles = 8;
  localparam int RandomItems = 500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gpc_op_t     op = OpRead;
  logic [10:0] address = '0;
  logic [23:0] write_data = '0;
  logic [4:0]  sample_port = '0;
  logic [7:0]  pin_levels = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] read_data;
  logic [4:0]  drive_port;
  logic [7:0]  drive_levels;
  logic [7:0]  drive_enables;
  logic [7:0]  bank_irq;

  // Per-port register file as the block should hold it
  logic [7:0]  gpio_mode [32];
  logic [7:0]  gpio_oe [32];
  logic [7:0]  gpio_out [32];
  logic [7:0]  gpio_in [32];
  logic [7:0]  irq_status [32];
  logic [7:0]  irq_enable [32];
  logic [23:0] irq_level [32];
  logic [15:0] db_ctrl [32];
  logic [7:0]  db_count [32];

  gpc_result_t pending_results[$];
  int failures = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  int n_reads = 0, n_writes = 0, n_samples = 0, n_other = 0;
  int n_results = 0, n_irq_results = 0;

  gpio_port_controller #(
    .NUM_BANKS     (NumBanks),
    .PORTS_PER_BANK(PortsPerBank),
    .PINS_PER_PORT (PinsPerPort)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .address_i      (address),
    .write_data_i   (write_data),
    .sample_port_i  (sample_port),
    .pin_levels_i   (pin_levels),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_data_o    (read_data),
    .drive_port_o   (drive_port),
    .drive_levels_o (drive_levels),
    .drive_enables_o(drive_enables),
    .bank_irq_o     (bank_irq)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit port_present(logic [4:0] idx);
    return (int'(idx[4:2]) < NumBanks) && (int'(idx[1:0]) < PortsPerBank);
  endfunction

  // Update the register file for one transaction and return the result it produces
  function automatic gpc_result_t apply_transaction(gpc_item_t it);
    logic [4:0]  aidx, pidx;
    gpc_reg_t    rcode;
    logic [7:0]  p, now, old, hi_sel, edg_sel, dlt_sel, hit;
    logic [23:0] rdata;
    logic [7:0]  lines;
    gpc_result_t res;
    aidx  = {it.address[10:8], it.address[3:2]};
    rcode = it.address[7:4];
    pidx  = aidx;
    rdata = '0;
    p     = it.write_data[7:0] & PinMask;
    case (it.op)
      OpRead: begin
        if (port_present(aidx)) begin
          case (rcode)
            RegMode:    rdata = 24'(gpio_mode[aidx]);
            RegOutEn:   rdata = 24'(gpio_oe[aidx]);
            RegOut:     rdata = 24'(gpio_out[aidx]);
            RegIn:      rdata = 24'(gpio_in[aidx]);
            RegStatus:  rdata = 24'(irq_status[aidx]);
            RegEnable:  rdata = 24'(irq_enable[aidx]);
            RegLevel:   rdata = irq_level[aidx];
            RegDbCtrl:  rdata = 24'(db_ctrl[aidx]);
            RegDbCount: rdata = 24'(db_count[aidx]);
            default:    rdata = '0;
          endcase
        end
      end
      OpWrite: begin
        if (port_present(aidx)) begin
          case (rcode)
            RegMode:    gpio_mode[aidx] = p;
            RegOutEn:   gpio_oe[aidx] = p;
            RegOut:     gpio_out[aidx] = p;
            RegEnable:  irq_enable[aidx] = p;
            RegLevel:   irq_level[aidx] = it.write_data & {3{PinMask}};
            RegClear:   irq_status[aidx] = irq_status[aidx] & ~p;
            RegDbCtrl:  db_ctrl[aidx] = it.write_data[15:0] & {2{PinMask}};
            RegDbCount: db_count[aidx] = it.write_data[7:0];
            default: ;
          endcase
        end
      end
      OpSample: begin
        pidx = it.sample_port;
        if (port_present(pidx)) begin
          now     = it.pin_levels & PinMask;
          old     = gpio_in[pidx];
          hi_sel  = irq_level[pidx][7:0];
          edg_sel = irq_level[pidx][15:8];
          dlt_sel = irq_level[pidx][23:16];
          // level pins latch on a match, edge pins on the selected transition or any change
          hit = ((~edg_sel & ~(now ^ hi_sel)) |
                 (edg_sel & ((dlt_sel & (now ^ old)) |
                             (~dlt_sel & ((hi_sel & now & ~old) | (~hi_sel & old & ~now))))))
                & PinMask;
          irq_status[pidx] = irq_status[pidx] | hit;
          gpio_in[pidx]    = now;
        end
      end
      default: ;
    endcase
    lines = '0;
    for (int i = 0; i < 32; i++) begin
      if (port_present(5'(i)) && (irq_status[i] & irq_enable[i]) != 0) lines[i >> 2] = 1'b1;
    end
    res.read_data     = rdata;
    res.drive_port    = pidx;
    res.drive_levels  = port_present(pidx) ? gpio_out[pidx] : 8'h00;
    res.drive_enables = port_present(pidx) ? (gpio_oe[pidx] & gpio_mode[pidx]) : 8'h00;
    res.bank_irq      = lines;
    return res;
  endfunction

  task automatic note_failure(string msg);
    if (failures < 10) $display("%s", msg);
    failures++;
  endtask

  // Drive one transaction and hold it until accepted; call at a rising edge
  task automatic send_item(gpc_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= it.op;
    address     <= it.address;
    write_data  <= it.write_data;
    sample_port <= it.sample_port;
    pin_levels  <= it.pin_levels;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  function automatic gpc_item_t noise_item();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[49:0];
  endfunction

  task automatic access_reg(gpc_op_t o, logic [4:0] idx, gpc_reg_t rcode, logic [23:0] d);
    gpc_item_t it;
    it = noise_item();
    it.op = o;
    it.address = {idx[4:2], rcode, idx[1:0], it.address[1:0]};
    it.write_data = d;
    send_item(it);
  endtask

  task automatic sample_pins(logic [4:0] idx, logic [7:0] lv);
    gpc_item_t it;
    it = noise_item();
    it.op = OpSample;
    it.sample_port = idx;
    it.pin_levels = lv;
    send_item(it);
  endtask

  // Hold the input side until every outstanding result has been checked
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_register_map();
    // Top port, all-ones data: writable registers take it, read-only ones and holes ignore it
    access_reg(OpWrite, 5'd31, RegMode, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegOutEn, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegOut, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegIn, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegStatus, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegLevel, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegDbCtrl, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegDbCount, 24'hFFFFFF);
    access_reg(OpWrite, 5'd31, RegReserved, 24'hFFFFFF);
    access_reg(OpRead, 5'd31, RegMode, 24'h0);
    access_reg(OpRead, 5'd31, RegIn, 24'h0);
    access_reg(OpRead, 5'd31, RegLevel, 24'h0);
    access_reg(OpRead, 5'd31, RegDbCtrl, 24'h0);
    access_reg(OpRead, 5'd31, RegDbCount, 24'h0);
    access_reg(OpRead, 5'd31, RegClear, 24'h0);
    access_reg(OpRead, 5'd31, RegReserved, 24'h0);
  endtask

  task automatic test_interrupt_modes();
    gpc_item_t it;
    // pins 1:0 level, 3:2 rising/falling edge, 7:4 any change
    access_reg(OpWrite, 5'd0, RegLevel, {8'hF0, 8'hFC, 8'h05});
    access_reg(OpWrite, 5'd0, RegEnable, 24'h0000FF);
    sample_pins(5'd0, 8'h00);
    sample_pins(5'd0, 8'hFF);
    sample_pins(5'd0, 8'h0F);
    access_reg(OpRead, 5'd0, RegStatus, 24'h0);
    access_reg(OpWrite, 5'd0, RegClear, 24'h0000FF);
    it = noise_item();
    it.op = OpNone;
    send_item(it);
  endtask

  task automatic test_random_traffic();
    logic [4:0] hot[4];
    logic [4:0] idx;
    gpc_reg_t   rcode;
    gpc_item_t  it;
    int counted, n, pick, sel;
    foreach (hot[i]) hot[i] = 5'($urandom_range(0, 31));
    counted = 0;
    n = 0;
    while (counted < RandomItems) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == RandomItems / 2) wait_for_results();
      idx  = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 3)] : 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        sample_pins(idx, 8'($urandom()));
      end else if (pick < 64) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0, 1, 2: rcode = RegLevel;
          3:       rcode = RegEnable;
          4, 5:    rcode = RegClear;
          6:       rcode = RegMode;
          7:       rcode = RegOutEn;
          8:       rcode = RegOut;
          default: rcode = gpc_reg_t'($urandom_range(0, 15));
        endcase
        access_reg(OpWrite, idx, rcode, 24'($urandom()));
      end else if (pick < 96) begin
        rcode = ($urandom_range(0, 2) == 0) ? RegStatus : gpc_reg_t'($urandom_range(0, 15));
        access_reg(OpRead, idx, rcode, 24'($urandom()));
      end else begin
        it = noise_item();
        it.op = OpNone;
        send_item(it);
        counted--;
      end
      counted++;
      n++;
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : accept_monitor
    gpc_item_t it;
    if (rst_n && in_valid && in_stall === 1'b0) begin
      it = {op, address, write_data, sample_port, pin_levels};
      pending_results.push_back(apply_transaction(it));
      case (op)
        OpRead:   n_reads++;
        OpWrite:  n_writes++;
        OpSample: n_samples++;
        default:  n_other++;
      endcase
    end
  end

  always @(posedge clk) begin : result_checker
    gpc_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      n_results++;
      if (bank_irq != 0) n_irq_results++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result %0d: read_data %06h port %0d",
                               n_results, read_data, drive_port));
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.read_data)
          note_failure($sformatf("result %0d read_data: expected %06h, got %06h",
                                 n_results, want.read_data, read_data));
        if (drive_port !== want.drive_port)
          note_failure($sformatf("result %0d drive_port: expected %0d, got %0d",
                                 n_results, want.drive_port, drive_port));
        if (drive_levels !== want.drive_levels)
          note_failure($sformatf("result %0d drive_levels: expected %02h, got %02h",
                                 n_results, want.drive_levels, drive_levels));
        if (drive_enables !== want.drive_enables)
          note_failure($sformatf("result %0d drive_enables: expected %02h, got %02h",
                                 n_results, want.drive_enables, drive_enables));
        if (bank_irq !== want.bank_irq)
          note_failure($sformatf("result %0d bank_irq: expected %02h, got %02h",
                                 n_results, want.bank_irq, bank_irq));
      end
    end
  end

  // Stall the result side for a random number of cycles before each result
  initial begin : result_stall
    int hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 IdleLimit, pending_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) begin
      gpio_mode[i]  = '0;
      gpio_oe[i]    = '0;
      gpio_out[i]   = '0;
      gpio_in[i]    = '0;
      irq_status[i] = '0;
      irq_enable[i] = '0;
      irq_level[i]  = '0;
      db_ctrl[i]    = '0;
      db_count[i]   = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_map();
    wait_for_results();
    test_interrupt_modes();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d reads, %0d writes, %0d pin samples, %0d unused-op transactions",
             n_reads, n_writes, n_samples, n_other);
    $display("checked %0d results, %0d with a bank interrupt raised, %0d failures",
             n_results, n_irq_results, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
